// ===== hdl/p1280_pkg.sv =====
// Shared types, codes and constants for the perm1280 sponge state engine.
// No dependencies; every other file in hdl/ imports this package.
package p1280_pkg;

  localparam int unsigned LANE_W     = 64;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned ROWS       = 5;
  localparam int unsigned COLUMNS    = 4;
  localparam int unsigned LANES      = ROWS * COLUMNS;
  localparam int unsigned WORDS      = 2 * LANES;
  localparam int unsigned RC_COUNT   = 12;
  localparam int unsigned MAX_ROUNDS = 12;
  localparam int unsigned RC_IDX_W   = 4;
  localparam int unsigned LANE_IDX_W = $clog2(LANES);

  typedef logic [LANE_W-1:0] lane_t;
  typedef logic [LANES-1:0][LANE_W-1:0] pstate_t;
  typedef logic [RC_IDX_W-1:0] rc_idx_t;

  typedef enum logic [2:0] {
    KIND_CLEAR     = 3'd0,
    KIND_XOR       = 3'd1,
    KIND_OVERWRITE = 3'd2,
    KIND_READ      = 3'd3,
    KIND_PERMUTE   = 3'd4
  } kind_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Sequencer to datapath: apply one round with the given constant index.
  typedef struct packed {
    logic    round_en;
    rc_idx_t rc_idx;
  } round_ctrl_t;

  localparam lane_t ROUND_CONST [RC_COUNT] = '{
    64'h58,  64'h38, 64'h3C0, 64'hD0,  64'h120, 64'h14,
    64'h60,  64'h2C, 64'h380, 64'hF0,  64'h1A0, 64'h12
  };

endpackage

// ===== hdl/p1280_round.sv =====
// One full permutation round (iota, chi, rho, theta, rho) as a shared unit.
// Depends on p1280_pkg for the state type and round constant table.
module p1280_round
  import p1280_pkg::*;
(
  input  pstate_t st_i,
  input  rc_idx_t rc_idx_i,
  output pstate_t st_o
);

  localparam int unsigned RHO_SHIFT [ROWS] = '{0, 1, 3, 0, 2};
  localparam int unsigned RHO_ROT   [ROWS] = '{0, 5, 24, 1, 3};

  function automatic lane_t rotl(lane_t v, int unsigned k);
    return (v << k) | (v >> (LANE_W - k));
  endfunction

  function automatic pstate_t rho(pstate_t s);
    pstate_t r;
    r = s;
    for (int unsigned y = 1; y < ROWS; y++) begin
      for (int unsigned x = 0; x < COLUMNS; x++) begin
        r[y*COLUMNS + x] =
          rotl(s[y*COLUMNS + ((x + COLUMNS - RHO_SHIFT[y]) % COLUMNS)], RHO_ROT[y]);
      end
    end
    return r;
  endfunction

  pstate_t a, b, c, d;
  lane_t   par [COLUMNS];
  lane_t   eff [COLUMNS];
  lane_t   rc;

  always_comb begin
    rc = (rc_idx_i < RC_IDX_W'(RC_COUNT)) ? ROUND_CONST[rc_idx_i] : '0;
    // iota
    a = st_i;
    a[0] = st_i[0] ^ rc;
    // chi along each column
    for (int unsigned x = 0; x < COLUMNS; x++) begin
      for (int unsigned y = 0; y < ROWS; y++) begin
        b[y*COLUMNS + x] = a[y*COLUMNS + x]
          ^ (~a[((y + 1) % ROWS)*COLUMNS + x] & a[((y + 2) % ROWS)*COLUMNS + x]);
      end
    end
    c = rho(b);
    // theta: fold the parity of the previous column into each column
    for (int unsigned x = 0; x < COLUMNS; x++) begin
      par[x] = '0;
      for (int unsigned y = 0; y < ROWS; y++) begin
        par[x] = par[x] ^ c[y*COLUMNS + x];
      end
    end
    for (int unsigned x = 0; x < COLUMNS; x++) begin
      eff[x] = rotl(par[(x + COLUMNS - 1) % COLUMNS], 5)
             ^ rotl(par[(x + COLUMNS - 1) % COLUMNS], 14);
    end
    for (int unsigned x = 0; x < COLUMNS; x++) begin
      for (int unsigned y = 0; y < ROWS; y++) begin
        d[y*COLUMNS + x] = c[y*COLUMNS + x] ^ eff[x];
      end
    end
    st_o = rho(d);
  end

endmodule

// ===== hdl/p1280_seq.sv =====
// Round sequencer: counts the round constant index through a permute.
// Depends on p1280_pkg for the state enum and control struct.
module p1280_seq
  import p1280_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start_i,
  input  logic [RC_IDX_W-1:0] rounds_i,
  output logic                busy_o,
  output round_ctrl_t         ctrl_o
);

  seq_state_t state_r, state_nxt;
  rc_idx_t    idx_r, idx_nxt;
  rc_idx_t    n_rounds;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    n_rounds  = (rounds_i > RC_IDX_W'(MAX_ROUNDS)) ? RC_IDX_W'(MAX_ROUNDS) : rounds_i;
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ctrl_o    = '{round_en: 1'b0, rc_idx: idx_r};
    busy_o    = 1'b0;
    case (state_r)
      SEQ_IDLE: begin
        // start at the constant of the first of the last n rounds
        if (start_i && (n_rounds != '0)) begin
          state_nxt = SEQ_RUN;
          idx_nxt   = RC_IDX_W'(RC_COUNT) - n_rounds;
        end
      end
      SEQ_RUN: begin
        busy_o          = 1'b1;
        ctrl_o.round_en = 1'b1;
        if (idx_r == RC_IDX_W'(RC_COUNT - 1)) begin
          state_nxt = SEQ_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/perm1280_sponge_state_engine_core.sv =====
// Top level of the perm1280 sponge state engine: state registers, word access
// and result register. Depends on p1280_pkg, p1280_seq and p1280_round.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer: clear
//   the 1280-bit state, XOR or overwrite one 32-bit word under a byte mask,
//   read one word, or permute with the last n of 12 rounds (n clamped to 12).
//   Result channel (out_valid/out_ready) returns exactly one word per
//   command: the addressed word for a read, zero for every other kind.
//   Timing: the result is registered and shows in the cycle after the input
//   transfer, for every kind (a permute's zero result does not wait for the
//   rounds to finish).
//   Throughput: word commands are taken one per cycle, back to back, while
//   out_ready keeps the output register free. A permute runs one round per
//   cycle through the single shared round unit, and in_ready stays low while
//   the round counter in the sequencer steps through the rounds.
//   Stall: a waiting result holds the output register; in_ready drops until
//   it is taken, so no result is lost or overwritten.
//   Reset: synchronous, active low; the state clears to all zero, the
//   sequencer returns to idle and the output register empties.
module perm1280_sponge_state_engine_core
  import p1280_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [5:0]  in_word_index,
  input  logic [31:0] in_write_data,
  input  logic [3:0]  in_byte_mask,
  input  logic [3:0]  in_rounds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data
);

  pstate_t     state_r, state_nxt;
  pstate_t     round_out;
  logic        out_valid_r;
  logic [31:0] out_data_r, out_data_nxt;
  logic        in_xfer;
  logic        busy;
  round_ctrl_t rctrl;
  kind_t       kind;

  logic [LANE_IDX_W-1:0] lane_idx;
  logic                  word_ok;
  logic                  hi_half;
  logic [31:0]           bmask;
  lane_t                 wr_bits, wr_mask;
  lane_t                 cur_lane;

  assign kind     = kind_t'(in_kind);
  assign in_ready = !busy && (!out_valid_r || out_ready);
  assign in_xfer  = in_valid && in_ready;

  p1280_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (in_xfer && (kind == KIND_PERMUTE)),
    .rounds_i (in_rounds),
    .busy_o   (busy),
    .ctrl_o   (rctrl)
  );

  p1280_round u_round (
    .st_i     (state_r),
    .rc_idx_i (rctrl.rc_idx),
    .st_o     (round_out)
  );

  // Word addressing: lane is index/2, odd index selects the high half.
  always_comb begin
    word_ok  = (in_word_index < 6'(WORDS));
    lane_idx = in_word_index[LANE_IDX_W:1];
    hi_half  = in_word_index[0];
    bmask    = {{8{in_byte_mask[3]}}, {8{in_byte_mask[2]}},
                {8{in_byte_mask[1]}}, {8{in_byte_mask[0]}}};
    wr_bits  = hi_half ? {in_write_data & bmask, 32'h0} : {32'h0, in_write_data & bmask};
    wr_mask  = hi_half ? {bmask, 32'h0} : {32'h0, bmask};
    cur_lane = word_ok ? state_r[lane_idx] : '0;
  end

  always_comb begin
    state_nxt    = state_r;
    out_data_nxt = '0;
    if (rctrl.round_en) begin
      state_nxt = round_out;
    end else if (in_xfer) begin
      case (kind)
        KIND_CLEAR: begin
          state_nxt = '0;
        end
        KIND_XOR: begin
          if (word_ok) begin
            state_nxt[lane_idx] = state_r[lane_idx] ^ wr_bits;
          end
        end
        KIND_OVERWRITE: begin
          if (word_ok) begin
            state_nxt[lane_idx] = (state_r[lane_idx] & ~wr_mask) | wr_bits;
          end
        end
        KIND_READ: begin
          out_data_nxt = hi_half ? cur_lane[63:32] : cur_lane[31:0];
        end
        default: begin
          state_nxt = state_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // load the result on every input transfer; drop it once taken
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

// ===== hdl/p1280_chk.sv =====
// Port-level checker for the perm1280 sponge state engine, bound to the top.
// Depends on p1280_pkg for the command codes.
module p1280_chk
  import p1280_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_kind,
  input logic [3:0]  in_rounds,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("stalled result changed");

  // every transfer yields a result in the next cycle
  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("missing result after transfer");

  // non-read commands return zero
  a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind != KIND_READ) |=> out_read_data == 32'h0)
    else $error("non-read command returned nonzero data");

  // a permute with rounds to run blocks the input for the next cycle
  a_perm_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_kind == KIND_PERMUTE) && (in_rounds != 4'h0)
      |=> !in_ready)
    else $error("input taken during permute");

  // a full, stalled output register blocks the input
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

endmodule

bind perm1280_sponge_state_engine_core p1280_chk u_p1280_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for perm1280_sponge_state_engine_core: a queued driver,
// a result monitor and a cycle-free shadow model of the 1280-bit state.
// Depends on p1280_pkg and the core RTL in hdl/.
module tb;
  import p1280_pkg::*;

  // Kinds 5..7 are unassigned; the core must ignore them and return zero.
  localparam logic [2:0] KIND_SPARE_LO = 3'd5;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam int unsigned INDEX_TOP  = 63;
  localparam int unsigned RANDOM_CMDS = 950;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  word_index;
    logic [31:0] write_data;
    logic [3:0]  byte_mask;
    logic [3:0]  rounds;
  } sponge_cmd_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_kind = '0;
  logic [5:0]  in_word_index = '0;
  logic [31:0] in_write_data = '0;
  logic [3:0]  in_byte_mask = '0;
  logic [3:0]  in_rounds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_read_data;

  sponge_cmd_t  pending_cmds [$];
  logic [31:0]  expected_read_words [$];
  lane_t        shadow_lanes [LANES];
  int           issued_cnt = 0;
  int           accepted_cnt = 0;
  int           err_cnt = 0;
  int           cmd_total;
  logic         in_xfer = 1'b0;

  // Hold both sides free of random idling for one long stretch of commands.
  wire steady = (issued_cnt >= 350) && (issued_cnt < 520);

  perm1280_sponge_state_engine_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_word_index (in_word_index),
    .in_write_data (in_write_data),
    .in_byte_mask  (in_byte_mask),
    .in_rounds     (in_rounds),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow model of the permutation state
  // ---------------------------------------------------------------------------
  function automatic lane_t rotl(lane_t v, int unsigned k);
    return (v << k) | (v >> (LANE_W - k));
  endfunction

  // Rows 1..4 take a column-shifted, rotated copy of themselves; row 0 stays.
  function automatic void rho_shuffle();
    lane_t       t [COLUMNS];
    int unsigned sft;
    int unsigned rot;
    for (int unsigned y = 1; y < ROWS; y++) begin
      case (y)
        1: begin sft = 1; rot = 5;  end
        2: begin sft = 3; rot = 24; end
        3: begin sft = 0; rot = 1;  end
        default: begin sft = 2; rot = 3; end
      endcase
      for (int unsigned x = 0; x < COLUMNS; x++) t[x] = shadow_lanes[y*COLUMNS + x];
      for (int unsigned x = 0; x < COLUMNS; x++)
        shadow_lanes[y*COLUMNS + x] = rotl(t[(x + COLUMNS - sft) % COLUMNS], rot);
    end
  endfunction

  // Apply one command to the shadow state and return the word the core
  // must hand back for it.
  function automatic logic [31:0] predict_read_data(sponge_cmd_t c);
    lane_t       b [ROWS];
    lane_t       par [COLUMNS];
    lane_t       p;
    lane_t       e;
    logic [31:0] m;
    logic [31:0] word;
    int unsigned lane;
    int unsigned sh;
    int          n;
    bit          in_range;
    word = '0;
    for (int i = 0; i < 4; i++) m[8*i +: 8] = {8{c.byte_mask[i]}};
    lane = 32'(c.word_index) >> 1;
    sh = c.word_index[0] ? 32 : 0;
    in_range = c.word_index < WORDS;
    case (c.kind)
      KIND_CLEAR: begin
        for (int i = 0; i < LANES; i++) shadow_lanes[i] = '0;
      end
      KIND_XOR: begin
        if (in_range) shadow_lanes[lane] ^= lane_t'(c.write_data & m) << sh;
      end
      KIND_OVERWRITE: begin
        if (in_range)
          shadow_lanes[lane] = (shadow_lanes[lane] & ~(lane_t'(m) << sh)) |
                               (lane_t'(c.write_data & m) << sh);
      end
      KIND_READ: begin
        if (in_range) word = shadow_lanes[lane][sh +: 32];
      end
      KIND_PERMUTE: begin
        n = (c.rounds > MAX_ROUNDS) ? MAX_ROUNDS : c.rounds;
        // Run the tail of the constant table: n rounds use the last n entries.
        for (int i = int'(RC_COUNT) - n; i < int'(RC_COUNT); i++) begin
          shadow_lanes[0] ^= ROUND_CONST[i];
          // chi down each column, rows wrap mod 5
          for (int unsigned x = 0; x < COLUMNS; x++) begin
            for (int unsigned y = 0; y < ROWS; y++) b[y] = shadow_lanes[y*COLUMNS + x];
            for (int unsigned y = 0; y < ROWS; y++)
              shadow_lanes[y*COLUMNS + x] = b[y] ^ (~b[(y+1) % ROWS] & b[(y+2) % ROWS]);
          end
          rho_shuffle();
          // theta: fold the parity of the column to the left into each column
          for (int unsigned x = 0; x < COLUMNS; x++) begin
            par[x] = '0;
            for (int unsigned y = 0; y < ROWS; y++) par[x] ^= shadow_lanes[y*COLUMNS + x];
          end
          for (int unsigned x = 0; x < COLUMNS; x++) begin
            p = par[(x + COLUMNS - 1) % COLUMNS];
            e = rotl(p, 5) ^ rotl(p, 14);
            for (int unsigned y = 0; y < ROWS; y++) shadow_lanes[y*COLUMNS + x] ^= e;
          end
          rho_shuffle();
        end
      end
      default: ;
    endcase
    return word;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus construction
  // ---------------------------------------------------------------------------
  function automatic void queue_cmd(logic [2:0] kind, logic [5:0] widx,
                                    logic [31:0] wdata, logic [3:0] bmask,
                                    logic [3:0] nrounds);
    sponge_cmd_t c;
    c.kind       = kind;
    c.word_index = widx;
    c.write_data = wdata;
    c.byte_mask  = bmask;
    c.rounds     = nrounds;
    pending_cmds.push_back(c);
  endfunction

  // Mostly absorb / permute / squeeze traffic over valid words, with a thin
  // layer of clears, unassigned kinds and out-of-range indexes as noise.
  function automatic void queue_random_cmd();
    int unsigned r;
    logic [2:0]  kind;
    logic [5:0]  widx;
    logic [3:0]  bmask;
    logic [3:0]  nrounds;
    r = $urandom_range(0, 99);
    if (r < 3)       kind = KIND_CLEAR;
    else if (r < 33) kind = KIND_XOR;
    else if (r < 48) kind = KIND_OVERWRITE;
    else if (r < 75) kind = KIND_READ;
    else if (r < 94) kind = KIND_PERMUTE;
    else             kind = 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
    widx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(WORDS, INDEX_TOP))
                                        : 6'($urandom_range(0, WORDS - 1));
    bmask = ($urandom_range(0, 2) == 0) ? 4'hF : 4'($urandom_range(0, 15));
    nrounds = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15)) : 4'(MAX_ROUNDS);
    queue_cmd(kind, widx, $urandom, bmask, nrounds);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: advance on a transfer, hold while stalled, idle at random
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    sponge_cmd_t nxt;
    if (rst_n) begin
      if (!in_valid || in_xfer) begin
        if (pending_cmds.size() > 0 && (steady || $urandom_range(0, 99) >= 29)) begin
          nxt = pending_cmds.pop_front();
          issued_cnt++;
          in_valid      <= 1'b1;
          in_kind       <= nxt.kind;
          in_word_index <= nxt.word_index;
          in_write_data <= nxt.write_data;
          in_byte_mask  <= nxt.byte_mask;
          in_rounds     <= nxt.rounds;
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Result-side backpressure on the same random schedule.
      out_ready <= steady || ($urandom_range(0, 99) >= 29);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result transfer, then record the input transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    logic [31:0] want;
    sponge_cmd_t seen;
    in_xfer = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_read_words.size() == 0) begin
          err_cnt++;
          $display("%0t: result transfer with none outstanding, actual %h",
                   $time, out_read_data);
        end else begin
          want = expected_read_words.pop_front();
          if (out_read_data !== want) begin
            err_cnt++;
            $display("%0t: read_data mismatch, expected %h, actual %h",
                     $time, want, out_read_data);
          end
        end
      end
      if (in_valid && in_ready) begin
        in_xfer = 1'b1;
        accepted_cnt++;
        seen.kind       = in_kind;
        seen.word_index = in_word_index;
        seen.write_data = in_write_data;
        seen.byte_mask  = in_byte_mask;
        seen.rounds     = in_rounds;
        expected_read_words.push_back(predict_read_data(seen));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed corners, random traffic, drain, verdict
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < LANES; i++) shadow_lanes[i] = '0;

    // Fresh state reads zero; then the word-index and byte-mask extremes.
    queue_cmd(KIND_READ, 6'd0, $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_XOR, 6'd0, 32'hFFFF_FFFF, 4'hF, 4'($urandom));
    queue_cmd(KIND_XOR, 6'(WORDS - 1), 32'hA5A5_5A5A, 4'hF, 4'($urandom));
    queue_cmd(KIND_OVERWRITE, 6'd1, 32'h1234_5678, 4'h5, 4'($urandom));
    queue_cmd(KIND_OVERWRITE, 6'd0, 32'h0000_0000, 4'hA, 4'($urandom));
    // Empty byte mask must leave the state alone.
    queue_cmd(KIND_XOR, 6'd2, 32'hFFFF_FFFF, 4'h0, 4'($urandom));
    queue_cmd(KIND_OVERWRITE, 6'd3, 32'hFFFF_FFFF, 4'h0, 4'($urandom));
    // Word indexes past the state: writes dropped, reads return zero.
    queue_cmd(KIND_XOR, 6'(WORDS), 32'hFFFF_FFFF, 4'hF, 4'($urandom));
    queue_cmd(KIND_OVERWRITE, 6'(INDEX_TOP), 32'hFFFF_FFFF, 4'hF, 4'($urandom));
    queue_cmd(KIND_READ, 6'(INDEX_TOP), $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_READ, 6'(WORDS - 1), $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_READ, 6'd1, $urandom, 4'($urandom), 4'($urandom));
    // Zero rounds, one round, full count and a clamped count.
    queue_cmd(KIND_PERMUTE, 6'($urandom), $urandom, 4'($urandom), 4'd0);
    queue_cmd(KIND_PERMUTE, 6'($urandom), $urandom, 4'($urandom), 4'd1);
    queue_cmd(KIND_PERMUTE, 6'($urandom), $urandom, 4'($urandom), 4'(MAX_ROUNDS));
    queue_cmd(KIND_PERMUTE, 6'($urandom), $urandom, 4'($urandom), 4'hF);
    queue_cmd(KIND_READ, 6'd0, $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_READ, 6'(WORDS - 2), $urandom, 4'($urandom), 4'($urandom));
    // Unassigned kinds carry random fields and must do nothing.
    for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
      queue_cmd(3'(k), 6'($urandom), $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_READ, 6'd0, $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_CLEAR, 6'($urandom), $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_READ, 6'd0, $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_PERMUTE, 6'($urandom), $urandom, 4'($urandom), 4'd13);
    queue_cmd(KIND_READ, 6'd0, $urandom, 4'($urandom), 4'($urandom));
    queue_cmd(KIND_READ, 6'd1, $urandom, 4'($urandom), 4'($urandom));

    repeat (RANDOM_CMDS) queue_random_cmd();
    cmd_total = pending_cmds.size();

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: every command taken and every result returned, then linger
    // so that a stray extra result is still caught.
    while (accepted_cnt < cmd_total || expected_read_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_cnt == 0) begin
      $display("perm1280_sponge_state_engine_core verification clean");
    end else begin
      $display("perm1280_sponge_state_engine_core verification failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("perm1280_sponge_state_engine_core verification failed");
    $finish;
  end

endmodule
